// ===== src/assert_macros.svh =====
// Assertion macros included by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked implication check, same reset handling.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/i2d_pkg.sv =====
// Constants and helpers for the 128-bit integer to decimal text converter.
package i2d_pkg;

    localparam int VALUE_BITS   = 128;
    localparam int HALF_BITS    = VALUE_BITS / 2;
    localparam int DIGIT_COUNT  = 39;
    localparam int DIGIT_BITS   = 4;
    localparam int BCD_BITS     = DIGIT_COUNT * DIGIT_BITS;
    localparam int CNT_BITS     = $clog2(VALUE_BITS);
    localparam int DIG_IDX_BITS = $clog2(DIGIT_COUNT);
    localparam int CHAR_BITS    = 6;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 6'd57;

    localparam logic [CNT_BITS-1:0]     CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
    localparam logic [DIG_IDX_BITS-1:0] DIG_TOP  = DIG_IDX_BITS'(DIGIT_COUNT - 1);

    // Double dabble correction: a digit of 5 or more gets 3 added before the shift.
    function automatic logic [DIGIT_BITS-1:0] dd_adjust(input logic [DIGIT_BITS-1:0] d);
        dd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

// ===== src/int128_to_decimal_convert.sv =====
// Signed 128-bit integer to ASCII decimal text converter, top level.
//
// Input channel: i_valid / o_stall carry one signed 128-bit value as two
// 64-bit halves (i_value_high holds the sign in bit 63). A transfer happens
// when i_valid is high and o_stall is low; o_stall stays high from that
// transfer until the last character of the number is loaded for output.
// Output channel: o_valid / i_stall carry one ASCII character per transfer,
// o_last_char marking the final one. A minus sign leads a negative number,
// then the digits from the most significant, no leading zeros.
// Steps per item: a load (with negation), one shift-add-3 pass per input
// bit on the shared BCD shifter, a minus sign for a negative number, then
// the leading zeros skipped one digit at a time, one step to start
// emitting and one step per digit emitted.
// The output register holds a character while i_stall is high; the
// sequencer waits and nothing is lost. The final character may still wait
// there while the next input is accepted.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register.
module int128_to_decimal_convert
    import i2d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [HALF_BITS-1:0] i_value_high,
    input  logic [HALF_BITS-1:0] i_value_low,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CHAR_BITS-1:0] o_character,
    output logic                 o_last_char
);

`include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_SIGN  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [VALUE_BITS-1:0]     r_mag, n_mag;
    logic [BCD_BITS-1:0]       r_bcd, n_bcd;
    logic [CNT_BITS-1:0]       r_cnt, n_cnt;
    logic [DIG_IDX_BITS-1:0]   r_dig, n_dig;
    logic                      r_neg, n_neg;
    logic                      r_o_valid, n_o_valid;
    logic [CHAR_BITS-1:0]      r_char, n_char;
    logic                      r_last, n_last;

    logic [BCD_BITS-1:0]       bcd_adj;
    logic [BCD_BITS-1:0]       bcd_shifted;
    logic [DIGIT_BITS-1:0]     top_digit;
    logic [VALUE_BITS-1:0]     in_value;
    logic                      out_free;

    // Shared shift-add-3 unit: all digit lanes corrected, then one shift.
    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            bcd_adj[d*DIGIT_BITS +: DIGIT_BITS] = dd_adjust(r_bcd[d*DIGIT_BITS +: DIGIT_BITS]);
        end
    end

    assign bcd_shifted = {bcd_adj[BCD_BITS-2:0], r_mag[VALUE_BITS-1]};
    assign top_digit   = r_bcd[BCD_BITS-1 -: DIGIT_BITS];
    assign in_value    = {i_value_high, i_value_low};
    assign out_free    = !r_o_valid || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_neg     = r_neg;
        n_o_valid = r_o_valid && i_stall;
        n_char    = r_char;
        n_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value_high[HALF_BITS-1];
                    n_mag   = i_value_high[HALF_BITS-1] ? (~in_value + VALUE_BITS'(1))
                                                        : in_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_dig   = DIG_TOP;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_bcd = bcd_shifted;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = r_neg ? S_SIGN : S_SCAN;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_MINUS;
                    n_last    = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // skip leading zeros, but always keep the units digit
                if (top_digit == '0 && r_dig != '0) begin
                    n_bcd = {r_bcd[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_dig = r_dig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_ZERO + CHAR_BITS'(top_digit);
                    n_last    = (r_dig == '0);
                    n_bcd     = {r_bcd[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_dig     = r_dig - 1'b1;
                    if (r_dig == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_dig  <= n_dig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    // An accepted value starts a fresh conversion pass.
    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> (r_state == S_SHIFT && r_cnt == '0 && r_bcd == '0),
        "accepted value did not start a conversion")

    // A pending non-final character means the item is still being emitted.
    `ASSERT_IMPLY(a_mid_item, i_clk, i_rst_n, r_o_valid && !r_last,
        r_state == S_SCAN || r_state == S_EMIT, "non-final character outside emit phase")

    // Only a minus sign or a decimal digit is ever presented.
    `ASSERT_IMPLY(a_char_range, i_clk, i_rst_n, o_valid,
        o_character == CHAR_MINUS || (o_character >= CHAR_ZERO && o_character <= CHAR_NINE),
        "output character out of range")

endmodule
